[design/tvmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-view midpoint triangulation package
// Shared widths, pipeline constants and index helpers for the solver.
// ----------------------------------------------------------------------------
package tvmt_pkg;

   localparam int W_C     = 48;             // ray centre, Q31.16
   localparam int W_D     = 32;             // direction, Q1.30
   localparam int W_P     = 2 * W_D;        // direction outer product, Q3.60
   localparam int W_A     = 66;             // system matrix entry
   localparam int W_M     = 65;             // projector entry
   localparam int W_MC    = W_M + W_C;      // projector times centre
   localparam int W_R     = W_MC + 3;       // right-hand side, sum of six terms
   localparam int W_AA    = 2 * W_A;        // product of two matrix entries
   localparam int W_J     = W_AA + 1;       // adjugate entry
   localparam int W_DP    = W_A + W_J;      // determinant term
   localparam int W_DT    = W_DP + 2;       // determinant
   localparam int W_NP    = W_J + W_R;      // numerator term
   localparam int W_N     = W_NP + 2;       // numerator
   localparam int W_CSR   = 31;             // det_min register
   localparam int QBITS   = 48;             // quotient bits
   localparam int DET_SHIFT = 150;          // det_min scale against the determinant
   localparam int MUL_LAT = 7;              // latency of tvmt_mul
   localparam int DEPTH   = 3 + MUL_LAT + 2 + MUL_LAT + 3 + QBITS + 1;

   typedef logic signed [W_C-1:0] coord_type;
   typedef logic [W_CSR-1:0]      csr_type;

   // Index of entry (i, j) of a symmetric 3x3 matrix in its six stored entries.
   function automatic int sym(input int i, input int j);
      int lo;
      int hi;
      begin
         lo = (i < j) ? i : j;
         hi = (i < j) ? j : i;
         if (lo == 0) begin
            sym = hi;
         end else if (lo == 1) begin
            sym = hi + 2;
         end else begin
            sym = 5;
         end
      end
   endfunction

   function automatic int pair_i(input int k);
      begin
         pair_i = (k < 3) ? 0 : ((k < 5) ? 1 : 2);
      end
   endfunction

   function automatic int pair_j(input int k);
      begin
         pair_j = (k < 3) ? k : ((k < 5) ? k - 2 : 2);
      end
   endfunction

endpackage

[design/tvmt_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-view midpoint triangulation channels
// Ray-pair request, point response and det_min write channel.
// ----------------------------------------------------------------------------
interface tvmt_req_if;
   logic valid;
   logic ready;
   logic signed [tvmt_pkg::W_C-1:0] c1_x;
   logic signed [tvmt_pkg::W_C-1:0] c1_y;
   logic signed [tvmt_pkg::W_C-1:0] c1_z;
   logic signed [tvmt_pkg::W_D-1:0] d1_x;
   logic signed [tvmt_pkg::W_D-1:0] d1_y;
   logic signed [tvmt_pkg::W_D-1:0] d1_z;
   logic signed [tvmt_pkg::W_C-1:0] c2_x;
   logic signed [tvmt_pkg::W_C-1:0] c2_y;
   logic signed [tvmt_pkg::W_C-1:0] c2_z;
   logic signed [tvmt_pkg::W_D-1:0] d2_x;
   logic signed [tvmt_pkg::W_D-1:0] d2_y;
   logic signed [tvmt_pkg::W_D-1:0] d2_z;
   modport source (output valid, c1_x, c1_y, c1_z, d1_x, d1_y, d1_z,
                   c2_x, c2_y, c2_z, d2_x, d2_y, d2_z, input ready);
   modport sink (input valid, c1_x, c1_y, c1_z, d1_x, d1_y, d1_z,
                 c2_x, c2_y, c2_z, d2_x, d2_y, d2_z, output ready);
endinterface

interface tvmt_rsp_if;
   logic valid;
   logic ready;
   logic signed [tvmt_pkg::W_C-1:0] p_x;
   logic signed [tvmt_pkg::W_C-1:0] p_y;
   logic signed [tvmt_pkg::W_C-1:0] p_z;
   logic valid_res;
   modport source (output valid, p_x, p_y, p_z, valid_res, input ready);
   modport sink (input valid, p_x, p_y, p_z, valid_res, output ready);
endinterface

interface tvmt_csr_if;
   logic valid;
   logic ready;
   logic [tvmt_pkg::W_CSR-1:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[design/tvmt_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined signed multiplier
// Magnitudes are split into 32-bit limbs, limb products are summed by rows
// and a registered tree, and the sign is applied at the end.
// ----------------------------------------------------------------------------
module tvmt_mul #(
   parameter int WA = 64,
   parameter int WB = 64
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);

   localparam int NA = (WA + 31) / 32;
   localparam int NB = (WB + 31) / 32;
   localparam int WP = 32 * (NA + NB);
   localparam int WO = WA + WB;

   logic [WA-1:0]      abs_a;
   logic [WB-1:0]      abs_b;
   logic [32*NA-1:0]   ma_ff;
   logic [32*NB-1:0]   mb_ff;
   logic [5:0]         sg_ff;
   logic [63:0]        pp_ff [NA][NB];
   logic [WP-1:0]      row_in [8];
   logic [WP-1:0]      row_ff [8];
   logic [WP-1:0]      t4_ff [4];
   logic [WP-1:0]      t5_ff [2];
   logic [WP-1:0]      t6_ff;
   logic signed [WO-1:0] p_ff;

   assign abs_a = a[WA-1] ? WA'(-a) : WA'(a);
   assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

   // The even limb products of one row never overlap each other, nor do the odd ones, so each row is one add.
   always_comb begin
      logic [WP-1:0] ev;
      logic [WP-1:0] od;
      for (int i = 0; i < 8; i++) begin
         row_in[i] = '0;
      end
      for (int i = 0; i < NA; i++) begin
         ev = '0;
         od = '0;
         for (int j = 0; j < NB; j++) begin
            if (j % 2 == 0) begin
               ev = ev | (WP'(pp_ff[i][j]) << (32 * (i + j)));
            end else begin
               od = od | (WP'(pp_ff[i][j]) << (32 * (i + j)));
            end
         end
         row_in[i] = ev + od;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff <= (32*NA)'(abs_a);
         mb_ff <= (32*NB)'(abs_b);
         sg_ff <= {sg_ff[4:0], a[WA-1] ^ b[WB-1]};
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= 64'(ma_ff[32*i +: 32]) * 64'(mb_ff[32*j +: 32]);
            end
         end
         row_ff <= row_in;
         for (int k = 0; k < 4; k++) begin
            t4_ff[k] <= row_ff[2*k] + row_ff[2*k+1];
         end
         t5_ff[0] <= t4_ff[0] + t4_ff[1];
         t5_ff[1] <= t4_ff[2] + t4_ff[3];
         t6_ff    <= t5_ff[0] + t5_ff[1];
         p_ff     <= sg_ff[5] ? WO'(-t6_ff) : WO'(t6_ff);
      end
   end

   assign p = p_ff;

endmodule

[design/two_view_midpoint_triangulation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-view midpoint triangulation
// Exact adjugate solve of the midpoint normal equations for one ray pair.
// ----------------------------------------------------------------------------
// The block takes one ray pair per clock while the pipeline is not held
// and presents its point on the response channel in order, one response
// beat per request beat. The pipeline has 71 register stages: direction
// products, the system matrix, a pipelined multiplier pass for the adjugate
// and right-hand side, a second one for the determinant and numerators, and
// a restoring divider with one quotient bit per stage. The last stage is the
// response register; while it holds a beat that is not taken the whole
// pipeline holds, and req.ready is low.
// ----------------------------------------------------------------------------
module two_view_midpoint_triangulation (
   input  logic          clock,
   input  logic          reset,
   tvmt_req_if.sink      req,
   tvmt_rsp_if.source    rsp,
   tvmt_csr_if.sink      csr
);

   localparam int WC = tvmt_pkg::W_C;
   localparam int WD = tvmt_pkg::W_D;
   localparam int WP = tvmt_pkg::W_P;
   localparam int WA = tvmt_pkg::W_A;
   localparam int WM = tvmt_pkg::W_M;
   localparam int WMC = tvmt_pkg::W_MC;
   localparam int WR = tvmt_pkg::W_R;
   localparam int WAA = tvmt_pkg::W_AA;
   localparam int WJ = tvmt_pkg::W_J;
   localparam int WDP = tvmt_pkg::W_DP;
   localparam int WDT = tvmt_pkg::W_DT;
   localparam int WNP = tvmt_pkg::W_NP;
   localparam int WN = tvmt_pkg::W_N;
   localparam int QB = tvmt_pkg::QBITS;
   localparam int DEPTH = tvmt_pkg::DEPTH;

   logic adv;
   logic vld_ff [DEPTH];
   tvmt_pkg::csr_type det_min_ff;

   // stage 0: input
   logic signed [WC-1:0] c1_ff [3];
   logic signed [WC-1:0] c2_ff [3];
   logic signed [WD-1:0] d1_ff [3];
   logic signed [WD-1:0] d2_ff [3];
   // stage 1: outer products
   logic signed [WP-1:0] p1_ff [6];
   logic signed [WP-1:0] p2_ff [6];
   logic signed [WC-1:0] c1s1_ff [3];
   logic signed [WC-1:0] c2s1_ff [3];
   // stage 2: matrix and projectors
   logic signed [WA-1:0] a_ff [6];
   logic signed [WM-1:0] m1_ff [6];
   logic signed [WM-1:0] m2_ff [6];
   logic signed [WC-1:0] c1s2_ff [3];
   logic signed [WC-1:0] c2s2_ff [3];
   logic signed [WA-1:0] a0d_ff [9][3];
   // multiplier pass one
   logic signed [WMC-1:0] mc1_w [3][3];
   logic signed [WMC-1:0] mc2_w [3][3];
   logic signed [WAA-1:0] at_w [6];
   logic signed [WAA-1:0] au_w [6];
   // stages 10 and 11
   logic signed [WJ-1:0] adj_ff [6];
   logic signed [WJ-1:0] adj11_ff [6];
   logic signed [WR-1:0] rsa_ff [3];
   logic signed [WR-1:0] rsb_ff [3];
   logic signed [WR-1:0] rhs_ff [3];
   // multiplier pass two
   logic signed [WDP-1:0] dt_w [3];
   logic signed [WNP-1:0] nm_w [3][3];
   // stages 19 and 20
   logic signed [WDT-1:0] det_ff;
   logic signed [WN-1:0]  num_ff [3];
   logic [WDT-1:0] mdet_ff;
   logic           dneg_ff;
   logic           dzero_ff;
   logic [WN-1:0]  mn_ff [3];
   logic           nneg_ff [3];
   // divider, index 0 is stage 21
   logic [WDT-1:0] md_ff [QB+1];
   logic [WN-1:0]  rem_ff [QB+1][3];
   logic [WN-1:0]  rem_in [QB+1][3];
   logic [QB-1:0]  q_ff [QB+1][3];
   logic [QB-1:0]  q_in [QB+1][3];
   logic           ovf_ff [QB+1][3];
   logic           neg_ff [QB+1][3];
   logic           sing_ff [QB+1];
   // response
   tvmt_pkg::coord_type px_ff;
   tvmt_pkg::coord_type py_ff;
   tvmt_pkg::coord_type pz_ff;
   logic                vres_ff;

   logic signed [WA-1:0] a_in [6];
   logic signed [WM-1:0] m1_in [6];
   logic signed [WM-1:0] m2_in [6];
   logic [WC-1:0]        pt_in [3];
   logic                 sat_in [3];

   assign adv       = !vld_ff[DEPTH-1] || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_min_ff <= tvmt_pkg::W_CSR'(1);
      end else if (csr.valid) begin
         det_min_ff <= csr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < DEPTH; n++) begin
            vld_ff[n] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req.valid;
         for (int n = 1; n < DEPTH; n++) begin
            vld_ff[n] <= vld_ff[n-1];
         end
      end
   end

   // A = 2I - d1 d1^T - d2 d2^T at 2^60, projectors I - d d^T at 2^60.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         if (tvmt_pkg::pair_i(k) == tvmt_pkg::pair_j(k)) begin
            a_in[k]  = (WA'(1) <<< 61) - WA'(p1_ff[k]) - WA'(p2_ff[k]);
            m1_in[k] = (WM'(1) <<< 60) - WM'(p1_ff[k]);
            m2_in[k] = (WM'(1) <<< 60) - WM'(p2_ff[k]);
         end else begin
            a_in[k]  = -WA'(p1_ff[k]) - WA'(p2_ff[k]);
            m1_in[k] = -WM'(p1_ff[k]);
            m2_in[k] = -WM'(p2_ff[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff <= '{req.c1_x, req.c1_y, req.c1_z};
         c2_ff <= '{req.c2_x, req.c2_y, req.c2_z};
         d1_ff <= '{req.d1_x, req.d1_y, req.d1_z};
         d2_ff <= '{req.d2_x, req.d2_y, req.d2_z};
         for (int k = 0; k < 6; k++) begin
            p1_ff[k] <= WP'(d1_ff[tvmt_pkg::pair_i(k)]) * WP'(d1_ff[tvmt_pkg::pair_j(k)]);
            p2_ff[k] <= WP'(d2_ff[tvmt_pkg::pair_i(k)]) * WP'(d2_ff[tvmt_pkg::pair_j(k)]);
         end
         c1s1_ff <= c1_ff;
         c2s1_ff <= c2_ff;
         a_ff    <= a_in;
         m1_ff   <= m1_in;
         m2_ff   <= m2_in;
         c1s2_ff <= c1s1_ff;
         c2s2_ff <= c2s1_ff;
         for (int j = 0; j < 3; j++) begin
            a0d_ff[0][j] <= a_ff[tvmt_pkg::sym(0, j)];
         end
         for (int n = 1; n < 9; n++) begin
            a0d_ff[n] <= a0d_ff[n-1];
         end
      end
   end

   // First multiplier pass: projector times centre, and adjugate cofactors.
   for (genvar i = 0; i < 3; i++) begin : g_rhs_i
      for (genvar j = 0; j < 3; j++) begin : g_rhs_j
         tvmt_mul #(.WA(WM), .WB(WC)) u_mc1 (
            .clock (clock), .en (adv),
            .a (m1_ff[tvmt_pkg::sym(i, j)]), .b (c1s2_ff[j]), .p (mc1_w[i][j]));
         tvmt_mul #(.WA(WM), .WB(WC)) u_mc2 (
            .clock (clock), .en (adv),
            .a (m2_ff[tvmt_pkg::sym(i, j)]), .b (c2s2_ff[j]), .p (mc2_w[i][j]));
      end
   end

   for (genvar k = 0; k < 6; k++) begin : g_adj
      localparam int I  = tvmt_pkg::pair_i(k);
      localparam int J  = tvmt_pkg::pair_j(k);
      localparam int I1 = (I + 1) % 3;
      localparam int I2 = (I + 2) % 3;
      localparam int J1 = (J + 1) % 3;
      localparam int J2 = (J + 2) % 3;
      tvmt_mul #(.WA(WA), .WB(WA)) u_at (
         .clock (clock), .en (adv),
         .a (a_ff[tvmt_pkg::sym(J1, I1)]), .b (a_ff[tvmt_pkg::sym(J2, I2)]),
         .p (at_w[k]));
      tvmt_mul #(.WA(WA), .WB(WA)) u_au (
         .clock (clock), .en (adv),
         .a (a_ff[tvmt_pkg::sym(J1, I2)]), .b (a_ff[tvmt_pkg::sym(J2, I1)]),
         .p (au_w[k]));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 6; k++) begin
            adj_ff[k] <= WJ'(at_w[k]) - WJ'(au_w[k]);
         end
         for (int i = 0; i < 3; i++) begin
            rsa_ff[i] <= WR'(mc1_w[i][0]) + WR'(mc1_w[i][1]) + WR'(mc1_w[i][2]);
            rsb_ff[i] <= WR'(mc2_w[i][0]) + WR'(mc2_w[i][1]) + WR'(mc2_w[i][2]);
            rhs_ff[i] <= rsa_ff[i] + rsb_ff[i];
         end
         adj11_ff <= adj_ff;
      end
   end

   // Second multiplier pass: determinant by the first row, and adj times rhs.
   for (genvar j = 0; j < 3; j++) begin : g_det
      tvmt_mul #(.WA(WA), .WB(WJ)) u_dt (
         .clock (clock), .en (adv),
         .a (a0d_ff[8][j]), .b (adj11_ff[tvmt_pkg::sym(j, 0)]), .p (dt_w[j]));
   end

   for (genvar i = 0; i < 3; i++) begin : g_num_i
      for (genvar j = 0; j < 3; j++) begin : g_num_j
         tvmt_mul #(.WA(WJ), .WB(WR)) u_nm (
            .clock (clock), .en (adv),
            .a (adj11_ff[tvmt_pkg::sym(i, j)]), .b (rhs_ff[j]), .p (nm_w[i][j]));
      end
   end

   // Restoring division, one quotient bit per stage, most significant first.
   always_comb begin
      logic [WN-1:0] sub;
      logic          ge;
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = '0;
         q_in[0][i]   = '0;
      end
      for (int t = 0; t < QB; t++) begin
         for (int i = 0; i < 3; i++) begin
            sub = WN'(md_ff[t]) << (QB - 1 - t);
            ge  = rem_ff[t][i] >= sub;
            rem_in[t+1][i] = ge ? rem_ff[t][i] - sub : rem_ff[t][i];
            q_in[t+1][i]   = {q_ff[t][i][QB-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff <= WDT'(dt_w[0]) + WDT'(dt_w[1]) + WDT'(dt_w[2]);
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= WN'(nm_w[i][0]) + WN'(nm_w[i][1]) + WN'(nm_w[i][2]);
         end
         mdet_ff  <= det_ff[WDT-1] ? WDT'(-det_ff) : WDT'(det_ff);
         dneg_ff  <= det_ff[WDT-1];
         dzero_ff <= det_ff == '0;
         for (int i = 0; i < 3; i++) begin
            mn_ff[i]   <= num_ff[i][WN-1] ? WN'(-num_ff[i]) : WN'(num_ff[i]);
            nneg_ff[i] <= num_ff[i][WN-1];
         end
         md_ff[0]   <= mdet_ff;
         sing_ff[0] <= dzero_ff ||
                       (mdet_ff < (WDT'(det_min_ff) << tvmt_pkg::DET_SHIFT));
         for (int i = 0; i < 3; i++) begin
            rem_ff[0][i] <= mn_ff[i];
            q_ff[0][i]   <= '0;
            ovf_ff[0][i] <= mn_ff[i] >= (WN'(mdet_ff) << QB);
            neg_ff[0][i] <= nneg_ff[i] ^ dneg_ff;
         end
         for (int t = 1; t <= QB; t++) begin
            md_ff[t]   <= md_ff[t-1];
            sing_ff[t] <= sing_ff[t-1];
            rem_ff[t]  <= rem_in[t];
            q_ff[t]    <= q_in[t];
            ovf_ff[t]  <= ovf_ff[t-1];
            neg_ff[t]  <= neg_ff[t-1];
         end
      end
   end

   // Saturate each quotient to the signed 48-bit range.
   always_comb begin
      logic [QB:0] q;
      for (int i = 0; i < 3; i++) begin
         q = ovf_ff[QB][i] ? ((QB+1)'(1) << (QB - 1)) + (QB+1)'(1)
                           : (QB+1)'(q_ff[QB][i]);
         if (!neg_ff[QB][i]) begin
            sat_in[i] = q > (((QB+1)'(1) << (QB - 1)) - (QB+1)'(1));
            pt_in[i]  = sat_in[i] ? {1'b0, {(QB-1){1'b1}}} : QB'(q);
         end else begin
            sat_in[i] = q > ((QB+1)'(1) << (QB - 1));
            pt_in[i]  = sat_in[i] ? {1'b1, {(QB-1){1'b0}}} : QB'(-q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (sing_ff[QB]) begin
            px_ff   <= '0;
            py_ff   <= '0;
            pz_ff   <= '0;
            vres_ff <= 1'b0;
         end else begin
            px_ff   <= pt_in[0];
            py_ff   <= pt_in[1];
            pz_ff   <= pt_in[2];
            vres_ff <= !(sat_in[0] || sat_in[1] || sat_in[2]);
         end
      end
   end

   assign rsp.valid     = vld_ff[DEPTH-1];
   assign rsp.p_x       = px_ff;
   assign rsp.p_y       = py_ff;
   assign rsp.p_z       = pz_ff;
   assign rsp.valid_res = vres_ff;

   a_stall_holds_input : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !req.ready)
      else $error("request taken while the response beat is stalled");

   a_pipe_advance : assert property (@(posedge clock) disable iff (reset)
      (!reset && adv) |=> (rsp.valid == $past(vld_ff[DEPTH-2])))
      else $error("valid bit lost or invented at the response stage");

   a_csr_write : assert property (@(posedge clock) disable iff (reset)
      csr.valid |=> (det_min_ff == $past(csr.data)))
      else $error("det_min write not taken");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-view midpoint triangulation testbench
// Drives ray pairs with random gaps and back-pressure. Each point is checked
// against a predictor that solves the exact integer system, or against the
// typed value of a directed table row. The det_min threshold is rewritten
// between phases while the pipeline is empty.
module testbench;

   typedef logic signed [47:0] cen_type;
   typedef logic signed [31:0] dir_type;
   typedef logic signed [511:0] wide_type;

   typedef struct {
      cen_type c1 [3];
      dir_type d1 [3];
      cen_type c2 [3];
      dir_type d2 [3];
   } ray_pair_type;

   typedef struct {
      cen_type p [3];
      logic    ok;
   } point_type;

   typedef struct {
      ray_pair_type rays;
      logic         typed;
      point_type    want;
   } table_row_type;

   localparam cen_type CMAX = 48'sh7FFFFFFFFFFF;
   localparam cen_type CMIN = -48'sh800000000000;
   localparam dir_type ONE  = 32'sh40000000;
   localparam int HOLD_CYCLES = 300;

   logic clock;
   logic reset;
   logic failed = 1'b0;
   logic hold_go = 1'b0;
   logic hold_done;
   int   hold_left;
   int   send_idle;
   int   take_idle;
   tvmt_pkg::csr_type thresh;
   point_type expected_points [$];
   table_row_type rows [$];

   tvmt_req_if req ();
   tvmt_rsp_if rsp ();
   tvmt_csr_if csr ();

   two_view_midpoint_triangulation u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp),
      .csr   (csr)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("testbench NOT OK");
      $finish;
   end

   // Signed truncating divide, saturated to 48 bits.
   function automatic cen_type quot48(input wide_type num, input wide_type den,
                                      inout logic ok);
      wide_type q;
      begin
         q = num / den;
         if (q > wide_type'(CMAX)) begin
            ok = 1'b0;
            return CMAX;
         end
         if (q < wide_type'(CMIN)) begin
            ok = 1'b0;
            return CMIN;
         end
         return cen_type'(q);
      end
   endfunction

   function automatic point_type solve_midpoint(input ray_pair_type r,
                                                input tvmt_pkg::csr_type dmin);
      wide_type a [3][3];
      wide_type adj [3][3];
      wide_type rhs [3];
      wide_type m1, m2, p1, p2, det, mdet, num;
      point_type res;
      begin
         for (int i = 0; i < 3; i++) begin
            rhs[i] = 0;
            for (int j = 0; j < 3; j++) begin
               p1 = wide_type'(r.d1[i]) * wide_type'(r.d1[j]);
               p2 = wide_type'(r.d2[i]) * wide_type'(r.d2[j]);
               m1 = ((i == j) ? (wide_type'(1) <<< 60) : 0) - p1;
               m2 = ((i == j) ? (wide_type'(1) <<< 60) : 0) - p2;
               a[i][j] = ((i == j) ? (wide_type'(1) <<< 61) : 0) - p1 - p2;
               rhs[i] = rhs[i] + m1 * wide_type'(r.c1[j]) + m2 * wide_type'(r.c2[j]);
            end
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               adj[i][j] = a[(j+1)%3][(i+1)%3] * a[(j+2)%3][(i+2)%3]
                         - a[(j+1)%3][(i+2)%3] * a[(j+2)%3][(i+1)%3];
            end
         end
         det = a[0][0] * adj[0][0] + a[0][1] * adj[1][0] + a[0][2] * adj[2][0];
         mdet = (det < 0) ? -det : det;
         res.ok = 1'b1;
         if (det == 0 || mdet < (wide_type'(dmin) <<< 150)) begin
            res.ok = 1'b0;
            for (int i = 0; i < 3; i++) res.p[i] = '0;
            return res;
         end
         for (int i = 0; i < 3; i++) begin
            num = adj[i][0] * rhs[0] + adj[i][1] * rhs[1] + adj[i][2] * rhs[2];
            res.p[i] = quot48(num, det, res.ok);
         end
         return res;
      end
   endfunction

   function automatic cen_type rand_cen(input int mode);
      begin
         case (mode)
            0: return cen_type'({$urandom, $urandom});
            1: return cen_type'($signed($urandom_range(0, 2000000)) - 1000000) <<< 16;
            default: return cen_type'($signed($urandom_range(0, 200000)) - 100000);
         endcase
      end
   endfunction

   function automatic dir_type rand_dir(input int mode);
      begin
         case (mode)
            0: return dir_type'($urandom);
            default: return dir_type'($signed($urandom_range(0, 2 * ONE)) - ONE);
         endcase
      end
   endfunction

   function automatic ray_pair_type rand_pair();
      ray_pair_type r;
      int mode;
      begin
         mode = $urandom_range(0, 9);
         for (int i = 0; i < 3; i++) begin
            r.c1[i] = rand_cen(mode < 2 ? 0 : (mode < 6 ? 1 : 2));
            r.c2[i] = rand_cen(mode < 2 ? 0 : (mode < 6 ? 1 : 2));
            r.d1[i] = rand_dir(mode == 0 ? 0 : 1);
            r.d2[i] = rand_dir(mode == 0 ? 0 : 1);
         end
         // Now and then the second ray runs almost along the first.
         if (mode == 9) begin
            for (int i = 0; i < 3; i++) r.d2[i] = r.d1[i] + dir_type'($urandom_range(0, 64));
         end
         return r;
      end
   endfunction

   // Called at a falling edge; valid stays high into the next beat when
   // there is no idle gap.
   task automatic send_pair(input ray_pair_type r);
      begin
         while ($urandom_range(0, 99) < send_idle) begin
            req.valid <= 1'b0;
            @(negedge clock);
         end
         req.valid <= 1'b1;
         req.c1_x <= r.c1[0]; req.c1_y <= r.c1[1]; req.c1_z <= r.c1[2];
         req.d1_x <= r.d1[0]; req.d1_y <= r.d1[1]; req.d1_z <= r.d1[2];
         req.c2_x <= r.c2[0]; req.c2_y <= r.c2[1]; req.c2_z <= r.c2[2];
         req.d2_x <= r.d2[0]; req.d2_y <= r.d2[1]; req.d2_z <= r.d2[2];
         do @(posedge clock); while (!req.ready);
         expected_points.insert(expected_points.size(), solve_midpoint(r, thresh));
         @(negedge clock);
      end
   endtask

   task automatic write_thresh(input tvmt_pkg::csr_type v);
      begin
         csr.valid <= 1'b1;
         csr.data  <= v;
         do @(posedge clock); while (!csr.ready);
         thresh = v;
         @(negedge clock);
         csr.valid <= 1'b0;
      end
   endtask

   task automatic drain();
      begin
         req.valid <= 1'b0;
         while (expected_points.size() != 0) @(negedge clock);
         repeat (tvmt_pkg::DEPTH + 10) @(negedge clock);
      end
   endtask

   task automatic add_row(input ray_pair_type r, input logic typed, input point_type want);
      table_row_type row;
      begin
         row.rays = r;
         row.typed = typed;
         row.want = want;
         rows.insert(rows.size(), row);
      end
   endtask

   // Response side: random stalls plus one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= take_idle);
      end
   end

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_points.size() == 0) begin
            $error("response beat with no request outstanding");
            failed = 1'b1;
         end else begin
            want = expected_points.pop_front();
            if (rsp.p_x !== want.p[0]) begin
               $error("p_x expected %0d actual %0d", want.p[0], rsp.p_x);
               failed = 1'b1;
            end
            if (rsp.p_y !== want.p[1]) begin
               $error("p_y expected %0d actual %0d", want.p[1], rsp.p_y);
               failed = 1'b1;
            end
            if (rsp.p_z !== want.p[2]) begin
               $error("p_z expected %0d actual %0d", want.p[2], rsp.p_z);
               failed = 1'b1;
            end
            if (rsp.valid_res !== want.ok) begin
               $error("valid_res expected %0b actual %0b", want.ok, rsp.valid_res);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      ray_pair_type r;
      point_type zero_pt, want;
      tvmt_pkg::csr_type settings [4];
      thresh = 1;
      send_idle = 0;
      take_idle = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      csr.valid = 1'b0;
      csr.data = '0;
      req.c1_x = '0; req.c1_y = '0; req.c1_z = '0;
      req.d1_x = '0; req.d1_y = '0; req.d1_z = '0;
      req.c2_x = '0; req.c2_y = '0; req.c2_z = '0;
      req.d2_x = '0; req.d2_y = '0; req.d2_z = '0;
      zero_pt.ok = 1'b0;
      for (int i = 0; i < 3; i++) zero_pt.p[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table. The first two typed rows are parallel rays, which
      // must come back as a singular zero point.
      for (int i = 0; i < 3; i++) begin
         r.c1[i] = '0; r.c2[i] = '0; r.d1[i] = '0; r.d2[i] = '0;
      end
      r.d1[0] = ONE; r.d2[0] = ONE;
      add_row(r, 1'b1, zero_pt);
      r.d2[0] = -ONE; r.c1[1] = CMAX; r.c2[2] = CMIN;
      add_row(r, 1'b1, zero_pt);
      // Perpendicular rays at the origin meet at the origin.
      r.d2[0] = '0; r.d2[1] = ONE; r.c1[1] = '0; r.c2[2] = '0;
      want.ok = 1'b1;
      for (int i = 0; i < 3; i++) want.p[i] = '0;
      add_row(r, 1'b1, want);
      r.c1[2] = 48'sh10000; r.c2[0] = -48'sh30000;
      add_row(r, 1'b0, want);
      r.c1[0] = CMAX; r.c1[1] = CMAX; r.c1[2] = CMAX;
      r.c2[0] = CMAX; r.c2[1] = CMAX; r.c2[2] = CMAX;
      add_row(r, 1'b0, want);
      r.c1[0] = CMIN; r.c1[1] = CMIN; r.c1[2] = CMIN;
      r.c2[0] = CMIN; r.c2[1] = CMIN; r.c2[2] = CMIN;
      add_row(r, 1'b0, want);
      // Zero directions give A = 2I.
      for (int i = 0; i < 3; i++) begin
         r.d1[i] = '0; r.d2[i] = '0;
      end
      add_row(r, 1'b0, want);
      // Extreme non-unit direction patterns.
      for (int i = 0; i < 3; i++) begin
         r.d1[i] = 32'sh7FFFFFFF; r.d2[i] = 32'sh80000000;
         r.c1[i] = CMAX; r.c2[i] = 48'sh1;
      end
      add_row(r, 1'b0, want);
      for (int i = 0; i < 3; i++) begin
         r.d1[i] = -ONE; r.d2[i] = ONE;
      end
      r.d1[1] = 32'sh12345;
      add_row(r, 1'b0, want);
      // Nearly parallel, small determinant.
      for (int i = 0; i < 3; i++) begin
         r.d1[i] = '0; r.d2[i] = '0; r.c1[i] = 48'sh50000; r.c2[i] = -48'sh20000;
      end
      r.d1[2] = ONE; r.d2[2] = ONE - 1; r.d2[0] = 32'sh8000;
      add_row(r, 1'b0, want);
      r.d2[0] = 32'sh1;
      add_row(r, 1'b0, want);

      foreach (rows[k]) begin
         send_pair(rows[k].rays);
         if (rows[k].typed) expected_points[$] = rows[k].want;
      end
      drain();

      settings[0] = 0;
      settings[1] = 31'h40000000;
      settings[2] = 31'h7FFFFFFF;
      settings[3] = 1;
      for (int ph = 0; ph < 4; ph++) begin
         write_thresh(settings[ph]);
         foreach (rows[k]) if (k >= 8) send_pair(rows[k].rays);
         drain();
      end

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 25 : ((ph == 1) ? 77 : 0);
         take_idle = (ph == 0) ? 77 : ((ph == 1) ? 25 : 0);
         if (ph == 2) hold_go = 1'b1;
         write_thresh((ph == 1) ? tvmt_pkg::csr_type'($urandom_range(0, 1 << 20))
                                : tvmt_pkg::csr_type'(1));
         for (int n = 0; n < 250; n++) send_pair(rand_pair());
         drain();
      end

      if (!failed) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end
endmodule
